/* hdl/bes_pkg.sv */
// Shared types and codes for the breakpoint envelope sampler.
// Point record layout, shaping request, controller states, command and register codes.
// No dependencies.
`default_nettype none

package bes_pkg;

  localparam int VALUE_W  = 18;
  localparam int MIN_SPAN = 7;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Resolved interpolation shape
  typedef enum logic [1:0] {
    SHAPE_LINEAR = 2'd0,
    SHAPE_STEP   = 2'd1,
    SHAPE_SMOOTH = 2'd2
  } shape_mode_t;

  // Per-point curve codes
  localparam logic [1:0] CURVE_INHERIT = 2'd0;
  localparam logic [1:0] CURVE_LINEAR  = 2'd1;
  localparam logic [1:0] CURVE_STEP    = 2'd2;
  localparam logic [1:0] CURVE_SMOOTH  = 2'd3;

  // Input commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_POINT_COUNT   = 2'd0;
  localparam logic [1:0] REG_DEFAULT_CURVE = 2'd1;
  localparam logic [1:0] REG_FALLBACK      = 2'd2;

  typedef struct packed {
    value_t     ptime;
    value_t     pvalue;
    logic [1:0] curve;
  } point_t;

  typedef struct packed {
    logic        start;
    shape_mode_t mode;
  } shape_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_SHAPE,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* hdl/bes_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bes_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/bes_div.sv */
// Restoring divider for the local segment fraction, one quotient bit per cycle.
// Depends on nothing outside this file.
`default_nettype none

module bes_div #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [17:0]            num,
  input  wire logic [17:0]            den,
  output logic                        done,
  output logic [FRACTION_BITS:0]      quot
);

  localparam int QW   = FRACTION_BITS + 1;
  localparam int CNTW = $clog2(QW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [17:0]     rem_r;
  logic [17:0]     den_r;
  logic [QW-1:0]   quot_r;

  logic [18:0] trial;
  logic [18:0] diff;
  logic        ge;

  // First step weighs 2^FRACTION_BITS without a shift; later steps double the remainder
  assign trial = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[17:0] : trial[17:0];
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

/* hdl/bes_interp.sv */
// Four-stage shaping and interpolation pipeline: smoothstep, weight select,
// weight times value delta, floor shift and saturation. Uses bes_pkg.
`default_nettype none

module bes_interp #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bes_pkg::shape_req_t    req,
  input  wire logic [FRACTION_BITS:0] frac,
  input  wire bes_pkg::value_t        lv,
  input  wire bes_pkg::value_t        rv,
  output logic                        done,
  output bes_pkg::value_t             value
);
  import bes_pkg::*;

  localparam int FB = FRACTION_BITS;
  localparam int FW = FB + 1;
  localparam logic [FW-1:0] ONE_W     = {1'b1, {FB{1'b0}}};
  localparam logic [FB+1:0] THREE_ONE = {2'b11, {FB{1'b0}}};
  localparam logic signed [21:0] SUM_MAX = 22'sd131071;
  localparam logic signed [21:0] SUM_MIN = -22'sd131072;

  logic v1_r, v2_r, v3_r, v4_r;

  logic [FW-1:0]      f1_r, sq1_r, w2_r;
  logic [FB+1:0]      k1_r;
  shape_mode_t        mode1_r;
  value_t             lv1_r, lv2_r, lv3_r;
  logic signed [18:0] diff1_r, diff2_r;
  logic signed [FB+20:0] p3_r;
  value_t             value_r;

  logic [2*FB+1:0]       sq_full;
  logic [2*FB+2:0]       sm_full;
  logic [FW-1:0]         w_c;
  logic signed [18:0]    diff_c;
  logic signed [FB+20:0] p_c;
  logic signed [20:0]    q_c;
  logic signed [21:0]    sum_c;
  value_t                sat_c;

  assign sq_full = (2*FB+2)'(frac) * (2*FB+2)'(frac);
  assign diff_c  = {rv[17], rv} - {lv[17], lv};

  assign sm_full = (2*FB+3)'(sq1_r) * (2*FB+3)'(k1_r);

  always_comb begin
    case (mode1_r)
      SHAPE_STEP:   w_c = (f1_r < ONE_W) ? '0 : ONE_W;
      SHAPE_SMOOTH: w_c = sm_full[2*FB:FB];
      default:      w_c = f1_r;
    endcase
  end

  assign p_c   = $signed({1'b0, w2_r}) * diff2_r;
  // Arithmetic shift right by FB is the floor of the division
  assign q_c   = $signed(p3_r[FB+20:FB]);
  assign sum_c = {{4{lv3_r[17]}}, lv3_r} + {q_c[20], q_c};

  always_comb begin
    if (sum_c > SUM_MAX) begin
      sat_c = value_t'(SUM_MAX);
    end else if (sum_c < SUM_MIN) begin
      sat_c = value_t'(SUM_MIN);
    end else begin
      sat_c = sum_c[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r    <= frac;
    sq1_r   <= sq_full[2*FB:FB];
    k1_r    <= THREE_ONE - {frac, 1'b0};
    mode1_r <= req.mode;
    lv1_r   <= lv;
    diff1_r <= diff_c;

    w2_r    <= w_c;
    lv2_r   <= lv1_r;
    diff2_r <= diff1_r;

    p3_r    <= p_c;
    lv3_r   <= lv2_r;

    value_r <= sat_c;
  end

  assign done  = v4_r;
  assign value = value_r;

endmodule

`default_nettype wire

/* hdl/breakpoint_envelope_sampler.sv */
// Breakpoint envelope sampler top level: configuration registers, point table
// RAM, scan controller and output register. Uses bes_pkg, bes_ram, bes_div, bes_interp.
//
//  Channel  Direction  Handshake               Payload
//  in_      sink       in_valid / in_stall     command, point slot/time/value/curve, sample time
//  out_     source     out_valid / out_stall   envelope_value
//  APB      slave      psel/penable, pready=1  point_count, default_curve, fallback_value
//
// A write item is stored in the RAM at its accept edge. A sample with no points
// goes through ST_OUT to the output register, with one point through ST_ONE and
// ST_OUT. A sample matching a segment passes through a one-read-per-cycle RAM walk,
// the bit-serial divider and the four-stage shaping pipeline.
// Reset clears control state and registers; the table holds no valid bits and is
// defined only where written. A stalled result is held while the next item is accepted.
`default_nettype none

module breakpoint_envelope_sampler #(
  parameter int MAX_POINTS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,

  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_command,
  input  wire logic [3:0]      in_point_index,
  input  wire bes_pkg::value_t in_point_time,
  input  wire bes_pkg::value_t in_point_value,
  input  wire logic [1:0]      in_point_curve,
  input  wire bes_pkg::value_t in_sample_time,

  output logic                 out_valid,
  input  wire logic            out_stall,
  output bes_pkg::value_t      out_envelope_value,

  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [3:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bes_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = AW + 1;
  localparam int FW    = FRACTION_BITS + 1;
  localparam int ONE_Q = 1 << FRACTION_BITS;
  // Upper time clamp only bites when 1.0 fits the 18-bit time field
  localparam int T_MAX = (FRACTION_BITS < 17) ? ONE_Q : 131071;
  localparam value_t T_LIM = value_t'(T_MAX);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [4:0] point_count_r;
  logic [1:0] default_curve_r;
  value_t     fallback_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r   <= '0;
      default_curve_r <= '0;
      fallback_r      <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_POINT_COUNT:   point_count_r   <= pwdata[4:0];
        REG_DEFAULT_CURVE: default_curve_r <= pwdata[1:0];
        REG_FALLBACK:      fallback_r      <= pwdata[17:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POINT_COUNT:   prdata = {27'b0, point_count_r};
      REG_DEFAULT_CURVE: prdata = {30'b0, default_curve_r};
      REG_FALLBACK:      prdata = {{14{fallback_r[17]}}, fallback_r};
      default:           prdata = '0;
    endcase
  end

  // Effective point count: anything above the table depth acts as the full table
  logic [CW-1:0] n_c;
  assign n_c = (32'(point_count_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count_r);

  // ---------------------------------------------------------------------------
  // Point table
  // ---------------------------------------------------------------------------
  state_t        state_r, state_nxt;
  logic          in_acc;
  logic          slot_ok;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [$bits(point_t)-1:0] ram_rdata;
  point_t        wr_pt;
  point_t        rd_pt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // Writes to a slot beyond the table are ignored
  assign slot_ok  = (32'(in_point_index) < MAX_POINTS);
  assign ram_we   = in_acc && (in_command == CMD_WRITE) && slot_ok;
  assign wr_pt    = '{ptime: in_point_time, pvalue: in_point_value, curve: in_point_curve};
  assign rd_pt    = point_t'(ram_rdata);

  bes_ram #(
    .WIDTH($bits(point_t)),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_point_index)),
    .wdata(wr_pt),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Scan datapath
  // ---------------------------------------------------------------------------
  logic [CW-1:0] cnt_r, cnt_nxt;
  value_t        t_r, t_nxt;
  point_t        prev_r, prev_nxt;
  value_t        lv_r, lv_nxt;
  value_t        rv_r, rv_nxt;
  shape_mode_t   mode_r, mode_nxt;
  value_t        result_r, result_nxt;
  logic          out_valid_r, out_valid_nxt;
  value_t        out_value_r, out_value_nxt;

  value_t        t_clamp;
  logic          hit;
  logic [18:0]   d_full;
  logic [18:0]   span_full;
  logic [17:0]   span_c;
  shape_mode_t   mode_c;

  always_comb begin
    if (in_sample_time < 0) begin
      t_clamp = '0;
    end else if (in_sample_time > T_LIM) begin
      t_clamp = T_LIM;
    end else begin
      t_clamp = in_sample_time;
    end
  end

  // rd_pt is the right-hand point of the segment under test in ST_SCAN
  assign hit       = (t_r >= prev_r.ptime) && (t_r <= rd_pt.ptime);
  assign d_full    = {t_r[17], t_r} - {prev_r.ptime[17], prev_r.ptime};
  assign span_full = {rd_pt.ptime[17], rd_pt.ptime} - {prev_r.ptime[17], prev_r.ptime};
  // Floor short segments at the minimum span
  assign span_c    = (span_full[17:0] < 18'(MIN_SPAN)) ? 18'(MIN_SPAN) : span_full[17:0];

  // Curve of the right-hand point; inherit falls back to the default register
  always_comb begin
    case (rd_pt.curve)
      CURVE_INHERIT: begin
        case (default_curve_r)
          SHAPE_STEP:   mode_c = SHAPE_STEP;
          SHAPE_SMOOTH: mode_c = SHAPE_SMOOTH;
          default:      mode_c = SHAPE_LINEAR;
        endcase
      end
      CURVE_STEP:   mode_c = SHAPE_STEP;
      CURVE_SMOOTH: mode_c = SHAPE_SMOOTH;
      default:      mode_c = SHAPE_LINEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Divider and shaping pipeline
  // ---------------------------------------------------------------------------
  logic          div_start;
  logic          div_done;
  logic [FW-1:0] div_quot;
  logic [FW-1:0] f_c;
  shape_req_t    shp_req;
  logic          shp_done;
  value_t        shp_value;

  assign div_start = (state_r == ST_SCAN) && hit;

  bes_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (d_full[17:0]),
    .den  (span_c),
    .done (div_done),
    .quot (div_quot)
  );

  // Clamp the local fraction to 1.0
  assign f_c = (div_quot > FW'(ONE_Q)) ? FW'(ONE_Q) : div_quot;

  assign shp_req.start = (state_r == ST_DIV) && div_done;
  assign shp_req.mode  = mode_r;

  bes_interp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_interp (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (shp_req),
    .frac (f_c),
    .lv   (lv_r),
    .rv   (rv_r),
    .done (shp_done),
    .value(shp_value)
  );

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    prev_r      <= prev_nxt;
    lv_r        <= lv_nxt;
    rv_r        <= rv_nxt;
    mode_r      <= mode_nxt;
    result_r    <= result_nxt;
    out_value_r <= out_value_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    prev_nxt      = prev_r;
    lv_nxt        = lv_r;
    rv_nxt        = rv_r;
    mode_nxt      = mode_r;
    result_nxt    = result_r;
    ram_raddr     = '0;
    // Drop the held result once it has been taken
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;

    unique case (state_r)
      ST_IDLE: begin
        // Read address 0 is presented here so a sample finds point 0 next cycle
        if (in_acc && (in_command == CMD_SAMPLE)) begin
          if (n_c == '0) begin
            result_nxt = fallback_r;
            state_nxt  = ST_OUT;
          end else if (n_c == CW'(1)) begin
            state_nxt = ST_ONE;
          end else begin
            t_nxt     = t_clamp;
            state_nxt = ST_FIRST;
          end
        end
      end
      ST_ONE: begin
        result_nxt = rd_pt.pvalue;
        state_nxt  = ST_OUT;
      end
      ST_FIRST: begin
        // Hold point 0 as the left end, fetch point 1
        prev_nxt  = rd_pt;
        cnt_nxt   = CW'(1);
        ram_raddr = AW'(1);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // Prefetch the next point while the current segment is tested
        ram_raddr = cnt_r[AW-1:0] + AW'(1);
        if (hit) begin
          lv_nxt    = prev_r.pvalue;
          rv_nxt    = rd_pt.pvalue;
          mode_nxt  = mode_c;
          state_nxt = ST_DIV;
        end else if (cnt_r == n_c - CW'(1)) begin
          // No segment brackets the time: give the last point's value
          result_nxt = rd_pt.pvalue;
          state_nxt  = ST_OUT;
        end else begin
          prev_nxt = rd_pt;
          cnt_nxt  = cnt_r + CW'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        if (shp_done) begin
          result_nxt = shp_value;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        // Advance into the output register once it is free or being taken
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = result_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_envelope_value = out_value_r;

`ifndef SYNTHESIS
  // Table writes happen only between samples, so no read can overlap them
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("point table written while a sample is in flight");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide wait");

  a_shape_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    shp_done |-> (state_r == ST_SHAPE))
    else $error("shaping pipeline finished outside the shaping wait");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (div_quot <= FW'(ONE_Q)))
    else $error("segment fraction above 1.0");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < n_c))
    else $error("scan index ran past the point count");
`endif

endmodule

`default_nettype wire
